>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the glob matcher.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GWM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gwm_pkg.sv
// Shared types and constants of the glob wildcard matcher.
// No dependencies.
package gwm_pkg;

    localparam int MAX_LEN = 255;
    localparam int LEN_W   = 8;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [8:0]       t_sym;   // byte value, or END_MARK past a string end

    localparam t_sym END_MARK = 9'd256;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PAT   = 2'd1;
    localparam logic [1:0] OP_TGT   = 2'd2;
    localparam logic [1:0] OP_RUN   = 2'd3;

    localparam logic [1:0] ST_MATCH   = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic [1:0] MODE_IMM   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BSLS  = 8'h5C;

endpackage

>>> hdl/glob_wildcard_matcher.sv
// Glob wildcard matcher: pattern and target stores plus the scan sequencer.
// Depends on gwm_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_s_*): each beat carries a command in i_s_tuser and a byte
//   in i_s_tdata. Clear empties both strings, append-pattern and append-target
//   write one byte each (bytes past 255 are dropped), run matches the whole
//   target against the glob pattern.
//   Output channel (o_m_*): one beat per run, status in o_m_tdata[1:0]
//   (match, no match, malformed pattern). Other commands give no beat.
//   Throughput: clear and append take one beat per cycle while the input is
//   ready. A run walks both stores through one registered read port each;
//   every scan step has a fetch state and an evaluate state, and a segment
//   between two stars is retried at each target offset. Result appears the
//   cycle after the scan ends.
//   The input is not ready while a run is active, nor while an earlier
//   result still waits on a stalled receiver; the result register holds
//   until it is taken.
//   Reset empties both strings and drops any pending result; store contents
//   are left as they are.
`include "assert_macros.svh"

module glob_wildcard_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_byte
    input  logic [1:0] i_s_tuser,   // [1:0] opcode
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] status, [7:2] zero
);
    import gwm_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_START_F  = 5'd1;
    localparam logic [4:0] S_START    = 5'd2;
    localparam logic [4:0] S_MEAS_F   = 5'd3;
    localparam logic [4:0] S_MEAS     = 5'd4;
    localparam logic [4:0] S_MESC_F   = 5'd5;
    localparam logic [4:0] S_MESC     = 5'd6;
    localparam logic [4:0] S_SEG      = 5'd7;
    localparam logic [4:0] S_MH_F     = 5'd8;
    localparam logic [4:0] S_MH       = 5'd9;
    localparam logic [4:0] S_MHESC_F  = 5'd10;
    localparam logic [4:0] S_MHESC    = 5'd11;
    localparam logic [4:0] S_SNEG_F   = 5'd12;
    localparam logic [4:0] S_SNEG     = 5'd13;
    localparam logic [4:0] S_SLO_F    = 5'd14;
    localparam logic [4:0] S_SLO      = 5'd15;
    localparam logic [4:0] S_SLOESC_F = 5'd16;
    localparam logic [4:0] S_SLOESC   = 5'd17;
    localparam logic [4:0] S_SDASH_F  = 5'd18;
    localparam logic [4:0] S_SDASH    = 5'd19;
    localparam logic [4:0] S_SHI_F    = 5'd20;
    localparam logic [4:0] S_SHI      = 5'd21;
    localparam logic [4:0] S_SHIESC_F = 5'd22;
    localparam logic [4:0] S_SHIESC   = 5'd23;

    localparam t_len LEN_MAX = t_len'(MAX_LEN);

    // Byte stores, one write and one registered read port each.
    logic [7:0] pat_mem [0:(1<<LEN_W)-1];
    logic [7:0] tgt_mem [0:(1<<LEN_W)-1];
    logic [7:0] r_pat_q, r_tgt_q;

    logic [4:0] r_state, n_state;
    t_len       r_pl, n_pl, r_tl, n_tl;
    t_len       r_pp, n_pp, r_tp, n_tp;
    t_len       r_ss, n_ss, r_se, n_se, r_srl, n_srl;
    t_len       r_i, n_i, r_saved, n_saved;
    t_len       r_lo, n_lo;
    t_sym       r_tc, n_tc;
    logic [1:0] r_mode, n_mode;
    logic       r_in_set, n_in_set, r_star_br, n_star_br, r_cur_star, n_cur_star;
    logic       r_neg, n_neg, r_found, n_found;
    logic       r_ovalid, n_ovalid;
    logic [1:0] r_ostat, n_ostat;

    logic       s_acc;
    logic       p_end, t_end;
    t_sym       pc, tc;
    logic       fail, fin;
    logic [1:0] fin_st;
    logic       is_star;
    t_len       pp_inc;

    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_ostat};

    // Data of the current fetch belongs to r_pp / r_tp, which fetch states leave alone unless S_MH_F ends a segment.
    assign p_end  = (r_pp >= r_pl);
    assign t_end  = (r_tp >= r_tl);
    assign pc     = p_end ? END_MARK : {1'b0, r_pat_q};
    assign tc     = t_end ? END_MARK : {1'b0, r_tgt_q};
    assign pp_inc = r_pp + t_len'(1);

    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tuser == OP_PAT && r_pl != LEN_MAX) begin
            pat_mem[r_pl] <= i_s_tdata;
        end
        if (s_acc && i_s_tuser == OP_TGT && r_tl != LEN_MAX) begin
            tgt_mem[r_tl] <= i_s_tdata;
        end
        r_pat_q <= pat_mem[r_pp];
        r_tgt_q <= tgt_mem[r_tp];
    end

    always_comb begin
        n_state    = r_state;
        n_pl       = r_pl;
        n_tl       = r_tl;
        n_pp       = r_pp;
        n_tp       = r_tp;
        n_ss       = r_ss;
        n_se       = r_se;
        n_srl      = r_srl;
        n_i        = r_i;
        n_saved    = r_saved;
        n_lo       = r_lo;
        n_tc       = r_tc;
        n_mode     = r_mode;
        n_in_set   = r_in_set;
        n_star_br  = r_star_br;
        n_cur_star = r_cur_star;
        n_neg      = r_neg;
        n_found    = r_found;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_ostat    = r_ostat;
        fail       = 1'b0;
        fin        = 1'b0;
        fin_st     = ST_MATCH;
        is_star    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (i_s_tuser)
                        OP_CLEAR: begin
                            n_pl = '0;
                            n_tl = '0;
                        end
                        OP_PAT: if (r_pl != LEN_MAX) n_pl = r_pl + t_len'(1);
                        OP_TGT: if (r_tl != LEN_MAX) n_tl = r_tl + t_len'(1);
                        OP_RUN: begin
                            n_pp    = '0;
                            n_tp    = '0;
                            n_state = S_START_F;
                        end
                        default: ;
                    endcase
                end
            end
            S_START_F: n_state = S_START;
            S_START: begin
                n_srl    = '0;
                n_in_set = 1'b0;
                priority if (p_end) begin
                    fin = 1'b1;
                end else if (pc == {1'b0, CH_RBRK}) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else if (pc == {1'b0, CH_STAR}) begin
                    n_pp      = pp_inc;
                    n_ss      = pp_inc;
                    n_star_br = 1'b1;
                    n_state   = S_MEAS_F;
                end else begin
                    n_ss      = r_pp;
                    n_star_br = 1'b0;
                    n_state   = S_MEAS_F;
                end
            end
            S_MEAS_F: n_state = S_MEAS;
            S_MEAS: begin
                n_pp    = p_end ? r_pp : pp_inc;
                is_star = (pc == {1'b0, CH_STAR});
                if (r_in_set) begin
                    if (pc == {1'b0, CH_RBRK}) n_in_set = 1'b0;
                end else if (!p_end) begin
                    n_srl = r_srl + t_len'(1);
                end
                if (pc == {1'b0, CH_LBRK}) n_in_set = 1'b1;
                priority if (r_in_set && pc == {1'b0, CH_LBRK}) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else if (pc == {1'b0, CH_BSLS}) begin
                    n_state = S_MESC_F;
                end else if (p_end || is_star) begin
                    if (r_in_set) begin
                        fin    = 1'b1;
                        fin_st = ST_ERROR;
                    end else begin
                        // drop the closing star from the segment
                        n_se       = is_star ? pp_inc - t_len'(1) : r_pp;
                        n_srl      = is_star ? r_srl : r_srl;
                        n_cur_star = is_star;
                        n_state    = S_SEG;
                    end
                end else begin
                    n_state = S_MEAS_F;
                end
            end
            S_MESC_F: n_state = S_MESC;
            S_MESC: begin
                if (p_end) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else begin
                    n_pp    = pp_inc;
                    n_state = S_MEAS_F;
                end
            end
            S_SEG: begin
                n_saved = r_pp;
                n_pp    = r_ss;
                n_state = S_MH_F;
                priority if (!r_star_br) begin
                    n_mode = MODE_IMM;
                end else if (r_cur_star) begin
                    n_mode = MODE_FIRST;
                    n_i    = r_tp;
                end else if ((r_tl - r_tp) < r_srl) begin
                    fin    = 1'b1;
                    fin_st = ST_NOMATCH;
                end else begin
                    n_mode = MODE_LAST;
                    n_tp   = r_tl - r_srl;
                end
            end
            S_MH_F: begin
                if (r_pp >= r_se) begin
                    // segment fits here
                    n_pp      = r_saved;
                    n_ss      = r_saved;
                    n_srl     = '0;
                    n_in_set  = 1'b0;
                    n_star_br = 1'b1;
                    priority if (r_mode == MODE_FIRST) begin
                        n_state = S_MEAS_F;
                    end else if (r_mode == MODE_IMM && r_cur_star) begin
                        n_state = S_MEAS_F;
                    end else if (r_mode == MODE_IMM && r_tp < r_tl) begin
                        fin    = 1'b1;
                        fin_st = ST_NOMATCH;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_state = S_MH;
                end
            end
            S_MH: begin
                n_pp = pp_inc;
                n_tp = t_end ? r_tp : r_tp + t_len'(1);
                n_tc = tc;
                priority if (r_pat_q == CH_QUES) begin
                    if (t_end) fail = 1'b1;
                    else n_state = S_MH_F;
                end else if (r_pat_q == CH_LBRK) begin
                    n_state = S_SNEG_F;
                end else if (r_pat_q == CH_BSLS) begin
                    n_state = S_MHESC_F;
                end else if ({1'b0, r_pat_q} != tc) begin
                    fail = 1'b1;
                end else begin
                    n_state = S_MH_F;
                end
            end
            S_MHESC_F: n_state = S_MHESC;
            S_MHESC: begin
                n_pp = pp_inc;
                if ({1'b0, r_pat_q} != r_tc) fail = 1'b1;
                else n_state = S_MH_F;
            end
            S_SNEG_F: n_state = S_SNEG;
            S_SNEG: begin
                n_found = 1'b0;
                n_state = S_SLO_F;
                if (!p_end && r_pat_q == CH_CARET) begin
                    n_neg = 1'b1;
                    n_pp  = pp_inc;
                end else begin
                    n_neg = 1'b0;
                end
            end
            S_SLO_F: n_state = S_SLO;
            S_SLO: begin
                n_pp = pp_inc;
                priority if (p_end) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else if (r_pat_q == CH_RBRK) begin
                    if (r_tc != END_MARK && (r_found ^ r_neg)) n_state = S_MH_F;
                    else fail = 1'b1;
                end else if (r_pat_q == CH_DASH || r_pat_q == CH_STAR ||
                             r_pat_q == CH_QUES || r_pat_q == CH_LBRK) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else if (r_pat_q == CH_BSLS) begin
                    n_state = S_SLOESC_F;
                end else begin
                    n_lo    = r_pat_q;
                    n_state = S_SDASH_F;
                end
            end
            S_SLOESC_F: n_state = S_SLOESC;
            S_SLOESC: begin
                if (p_end) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else begin
                    n_pp    = pp_inc;
                    n_lo    = r_pat_q;
                    n_state = S_SDASH_F;
                end
            end
            S_SDASH_F: n_state = S_SDASH;
            S_SDASH: begin
                if (!p_end && r_pat_q == CH_DASH) begin
                    n_pp    = pp_inc;
                    n_state = S_SHI_F;
                end else begin
                    if (r_tc == {1'b0, r_lo}) n_found = 1'b1;
                    n_state = S_SLO_F;
                end
            end
            S_SHI_F: n_state = S_SHI;
            S_SHI: begin
                n_pp = pp_inc;
                priority if (p_end) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else if (r_pat_q == CH_BSLS) begin
                    n_state = S_SHIESC_F;
                end else begin
                    if (r_tc >= {1'b0, r_lo} && r_tc <= {1'b0, r_pat_q}) n_found = 1'b1;
                    n_state = S_SLO_F;
                end
            end
            S_SHIESC_F: n_state = S_SHIESC;
            S_SHIESC: begin
                if (p_end) begin
                    fin    = 1'b1;
                    fin_st = ST_ERROR;
                end else begin
                    n_pp = pp_inc;
                    if (r_tc >= {1'b0, r_lo} && r_tc <= {1'b0, r_pat_q}) n_found = 1'b1;
                    n_state = S_SLO_F;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A failed fit retries one target offset later in first-fit mode only.
        if (fail) begin
            if (r_mode == MODE_FIRST && r_i != r_tl) begin
                n_i     = r_i + t_len'(1);
                n_pp    = r_ss;
                n_tp    = r_i + t_len'(1);
                n_state = S_MH_F;
            end else begin
                fin    = 1'b1;
                fin_st = ST_NOMATCH;
            end
        end

        if (fin) begin
            n_state  = S_IDLE;
            n_ovalid = 1'b1;
            n_ostat  = fin_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pl     <= '0;
            r_tl     <= '0;
            r_pp     <= '0;
            r_tp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pl     <= n_pl;
            r_tl     <= n_tl;
            r_pp     <= n_pp;
            r_tp     <= n_tp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ss       <= n_ss;
        r_se       <= n_se;
        r_srl      <= n_srl;
        r_i        <= n_i;
        r_saved    <= n_saved;
        r_lo       <= n_lo;
        r_tc       <= n_tc;
        r_mode     <= n_mode;
        r_in_set   <= n_in_set;
        r_star_br  <= n_star_br;
        r_cur_star <= n_cur_star;
        r_neg      <= n_neg;
        r_found    <= n_found;
        r_ostat    <= n_ostat;
    end

    `GWM_ASSERT_IMP(a_pp_in_range, r_state != S_IDLE, r_pp <= r_pl,
        "pattern position past pattern end during a run")
    `GWM_ASSERT_IMP(a_tp_in_range, r_state != S_IDLE, r_tp <= r_tl,
        "target position past target end during a run")
    `GWM_ASSERT_NXT(a_run_busy, s_acc && i_s_tuser == OP_RUN, !o_s_tready,
        "input still ready after a run was taken")
    `GWM_ASSERT_IMP(a_status_code, o_m_tvalid,
        r_ostat == ST_MATCH || r_ostat == ST_NOMATCH || r_ostat == ST_ERROR,
        "result carries an unknown status code")

endmodule
